// File: hdl/zero_crossing_period_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// zero_crossing_period_tracker_core assertion macros
// Concurrent assertion helpers clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_PERIOD_TRACKER_CORE_ASSERT_SVH
`define ZERO_CROSSING_PERIOD_TRACKER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ZCPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("zcpt assertion failed");

// expression holds on every cycle out of reset
`define ZCPT_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("zcpt invariant failed");

`endif

// File: hdl/zcpt_pkg.sv
// ----------------------------------------------------------------------------
// zcpt_pkg
// Shared constants, state entry type and sign codes of the period tracker.
// ----------------------------------------------------------------------------
package zcpt_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 32;
    localparam int OUT_W    = 32;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam logic [1:0] CROSS_CLOSE = 2'd3;
    localparam logic [1:0] CROSS_FIRST = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]         last_sign;
        logic [1:0]         crossing;
        logic [COUNT_W-1:0] sample_cnt;
        logic [COUNT_W-1:0] shortest;
        logic [COUNT_W-1:0] longest;
    } t_entry;

endpackage

// File: hdl/zero_crossing_period_tracker_core.sv
// Pipeline: an accepted word and its state read are registered, then the result word.
// Throughput: one word per cycle while the sink is ready; state read on accept, updated
// and written back when it advances, with forwarding when the same channel follows itself.
// Reset: synchronous, active low; clears the per-channel valid flags of the
// state memory (no clearing pass) and empties the pipeline.
`include "zero_crossing_period_tracker_core_assert.svh"
// ----------------------------------------------------------------------------
// zero_crossing_period_tracker_core
// Per-channel zero crossing period tracker, min/max period per sample.
// ----------------------------------------------------------------------------
module zero_crossing_period_tracker_core
    import zcpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // channel[2:0], sample_bits[34:3]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // channel_out[2:0], min_period[34:3], max_period[66:35]
    output logic [0:0]  o_m_tuser    // period_closed[0]
);

    localparam logic [CH_W:0] CH_LIMIT = (CH_W+1)'(CHANNELS);

    logic                accept;
    logic                s1_adv;
    logic                wr_en;
    t_entry              rd_entry;
    t_entry              s1_entry;
    t_entry              upd_entry;
    logic                upd_closed;

    logic                r_s1_vld;
    logic [CH_W-1:0]     r_s1_ch;
    logic [SAMPLE_W-1:0] r_s1_bits;
    logic                r_s1_inrange;
    logic                r_fwd;
    logic                n_fwd;
    t_entry              r_fwd_entry;

    logic                r_out_vld;
    logic [CH_W-1:0]     r_out_ch;
    logic [OUT_W-1:0]    r_out_min;
    logic [OUT_W-1:0]    r_out_max;
    logic                r_out_closed;

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;
    assign wr_en      = s1_adv && r_s1_inrange;
    assign n_fwd      = wr_en && accept && (i_s_tdata[CH_W-1:0] == r_s1_ch);

    zcpt_state_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_s_tdata[CH_W-1:0]),
        .o_rd_data (rd_entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_ch),
        .i_wr_data (upd_entry)
    );

    assign s1_entry = r_fwd ? r_fwd_entry : rd_entry;

    zcpt_update u_upd (
        .i_bits   (r_s1_bits),
        .i_entry  (s1_entry),
        .o_entry  (upd_entry),
        .o_closed (upd_closed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
                r_fwd    <= n_fwd;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch      <= i_s_tdata[CH_W-1:0];
            r_s1_bits    <= i_s_tdata[CH_W+SAMPLE_W-1:CH_W];
            r_s1_inrange <= ({1'b0, i_s_tdata[CH_W-1:0]} < CH_LIMIT);
        end
        if (n_fwd) begin
            r_fwd_entry <= upd_entry;
        end
        if (s1_adv) begin
            r_out_ch <= r_s1_ch;
            if (r_s1_inrange) begin
                r_out_min    <= upd_entry.shortest[OUT_W-1:0];
                r_out_max    <= upd_entry.longest[OUT_W-1:0];
                r_out_closed <= upd_closed;
            end else begin
                r_out_min    <= '0;
                r_out_max    <= '0;
                r_out_closed <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out_max, r_out_min, r_out_ch};
    assign o_m_tuser  = r_out_closed;

    `ZCPT_ASSERT_IMP(a_closed_sets_both, r_out_vld && r_out_closed, r_out_min != '0 && r_out_max != '0)
    `ZCPT_ASSERT_IMP(a_min_le_max, r_out_vld, r_out_min <= r_out_max)
    `ZCPT_ASSERT_IMP(a_unset_together, r_out_vld, (r_out_min == '0) == (r_out_max == '0))
    `ZCPT_ASSERT_IMP(a_ready_when_empty, !r_out_vld, o_s_tready)

endmodule

// File: hdl/zcpt_state_ram.sv
// ----------------------------------------------------------------------------
// zcpt_state_ram
// Per-channel state memory, one read and one write port, registered read.
// Valid flags make unwritten entries read as the cleared state.
// ----------------------------------------------------------------------------
module zcpt_state_ram
    import zcpt_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [CH_W-1:0] i_rd_addr,
    output t_entry          o_rd_data,
    input  logic            i_wr_en,
    input  logic [CH_W-1:0] i_wr_addr,
    input  t_entry          i_wr_data
);

    t_entry               r_mem [CHANNELS];
    logic [CHANNELS-1:0]  r_vld;
    t_entry               r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: hdl/zcpt_update.sv
// ----------------------------------------------------------------------------
// zcpt_update
// Classifies one sample and computes the channel's next state entry.
// ----------------------------------------------------------------------------
module zcpt_update
    import zcpt_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_bits,
    input  t_entry              i_entry,
    output t_entry              o_entry,
    output logic                o_closed
);

    logic [1:0]         cls;
    logic               is_zero;
    logic               is_nan;
    logic               is_cross;
    logic [1:0]         cross_n;
    logic [COUNT_W-1:0] cnt_inc;

    always_comb begin
        is_zero = (i_bits[SAMPLE_W-2:0] == '0);
        is_nan  = (i_bits[SAMPLE_W-2:0] > 31'h7F80_0000);
        if (is_zero || is_nan) begin
            cls = SIGN_NONE;
        end else if (i_bits[SAMPLE_W-1]) begin
            cls = SIGN_NEG;
        end else begin
            cls = SIGN_POS;
        end

        cnt_inc  = (i_entry.sample_cnt != COUNT_MAX) ? i_entry.sample_cnt + 1'b1
                                                     : i_entry.sample_cnt;
        is_cross = is_zero
                || (cls == SIGN_NEG && i_entry.last_sign == SIGN_POS)
                || (cls == SIGN_POS && i_entry.last_sign == SIGN_NEG);
        cross_n  = i_entry.crossing + 2'd1;

        o_entry            = i_entry;
        o_entry.last_sign  = cls;
        o_entry.sample_cnt = cnt_inc;
        o_closed           = 1'b0;
        if (is_cross) begin
            o_entry.crossing = cross_n;
            if (cross_n == CROSS_CLOSE) begin
                o_closed           = 1'b1;
                o_entry.crossing   = CROSS_FIRST;
                o_entry.sample_cnt = {{(COUNT_W-1){1'b0}}, 1'b1};
                if (cnt_inc > i_entry.longest || i_entry.longest == '0) begin
                    o_entry.longest = cnt_inc;
                end
                if (cnt_inc < i_entry.shortest || i_entry.shortest == '0) begin
                    o_entry.shortest = cnt_inc;
                end
            end
        end
    end

endmodule

// File: sim/zero_crossing_period_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_period_tracker_core_test
// Streams interleaved per-channel float samples through the tracker (a short
// directed part, then random wave-like runs mixed with noise) under random
// bursts and sink stalls, and checks every result word against an in-bench
// model of the per-channel crossing, period and min/max state.
// ----------------------------------------------------------------------------
module zero_crossing_period_tracker_core_test;
    import zcpt_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [OUT_W-1:0] lo;
        logic [OUT_W-1:0] hi;
        logic             closed;
    } period_stats_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_EVERY4,
        STALL_HEAVY
    } stall_mode_t;

    localparam int RANDOM_WORDS = 600;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [71:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    logic [39:0]   word_q[$];
    period_stats_t stats_q[$];

    logic [1:0]         sign_r[CHANNELS];
    logic [1:0]         xing_r[CHANNELS];
    logic [COUNT_W-1:0] cnt_r[CHANNELS];
    logic [COUNT_W-1:0] shortest_r[CHANNELS];
    logic [COUNT_W-1:0] longest_r[CHANNELS];

    int          err_cnt    = 0;
    int          gap_left   = 0;
    int          burst_left = 1;
    int          stall_span = 0;
    int          stall_tick = 0;
    stall_mode_t stall_mode = STALL_NONE;

    zero_crossing_period_tracker_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // channel[2:0], sample_bits[34:3]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),  // channel_out[2:0], min_period[34:3], max_period[66:35]
        .o_m_tuser  (o_m_tuser)   // period_closed[0]
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void advance_channel(input logic [CH_W-1:0] ch,
                                            input logic [SAMPLE_W-1:0] bits);
        logic [30:0]   mag;
        logic [1:0]    cls;
        logic          is_zero;
        logic          is_cross;
        period_stats_t r;
        mag     = bits[30:0];
        is_zero = (mag == '0);
        if (is_zero || mag > 31'h7F80_0000)
            cls = SIGN_NONE;
        else if (bits[31])
            cls = SIGN_NEG;
        else
            cls = SIGN_POS;
        r.closed = 1'b0;
        if (cnt_r[ch] != COUNT_MAX)
            cnt_r[ch] = cnt_r[ch] + 1'b1;
        is_cross = is_zero || (cls == SIGN_NEG && sign_r[ch] == SIGN_POS)
                           || (cls == SIGN_POS && sign_r[ch] == SIGN_NEG);
        if (is_cross) begin
            xing_r[ch] = xing_r[ch] + 2'd1;
            if (xing_r[ch] == CROSS_CLOSE) begin
                xing_r[ch] = CROSS_FIRST;
                if (cnt_r[ch] > longest_r[ch] || longest_r[ch] == '0)
                    longest_r[ch] = cnt_r[ch];
                if (cnt_r[ch] < shortest_r[ch] || shortest_r[ch] == '0)
                    shortest_r[ch] = cnt_r[ch];
                cnt_r[ch] = {{(COUNT_W-1){1'b0}}, 1'b1};
                r.closed  = 1'b1;
            end
        end
        sign_r[ch] = cls;
        r.ch = ch;
        r.lo = shortest_r[ch];
        r.hi = longest_r[ch];
        stats_q = {stats_q, r};
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
        err_cnt++;
    endtask

    task automatic queue_word(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] bits);
        word_q = {word_q, {5'd0, bits, ch}};
    endtask

    task automatic queue_directed();
        queue_word(3'd0, 32'h3F80_0000);
        queue_word(3'd0, 32'hBF80_0000);
        queue_word(3'd7, 32'h3F80_0000);
        queue_word(3'd0, 32'h3F80_0000);
        queue_word(3'd7, 32'hFF80_0000);
        queue_word(3'd0, 32'hBF80_0000);
        queue_word(3'd0, 32'h0000_0000);
        queue_word(3'd0, 32'h8000_0000);
        queue_word(3'd3, 32'hBF80_0000);
        queue_word(3'd3, 32'h7FC0_0000);
        queue_word(3'd3, 32'h3F80_0000);
        queue_word(3'd3, 32'h7F80_0001);
        queue_word(3'd3, 32'hFFFF_FFFF);
        queue_word(3'd3, 32'hFF80_0000);
        queue_word(3'd3, 32'h7F80_0000);
        queue_word(3'd7, 32'h0000_0001);
        queue_word(3'd7, 32'h8000_0001);
        queue_word(3'd7, 32'h7F7F_FFFF);
        queue_word(3'd7, 32'hFF7F_FFFF);
        queue_word(3'd7, 32'h8000_0000);
        queue_word(3'd5, 32'h7FFF_FFFF);
        queue_word(3'd5, 32'h0000_0000);
        queue_word(3'd5, 32'h0000_0000);
        queue_word(3'd5, 32'h0000_0000);
    endtask

    // mostly alternating-sign runs per channel, some noise words
    task automatic queue_random();
        logic            wave_neg[CHANNELS];
        int              run_left[CHANNELS];
        logic [CH_W-1:0] ch;
        logic [31:0]     bits;
        ch = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            wave_neg[c] = 1'($urandom_range(0, 1));
            run_left[c] = $urandom_range(1, 12);
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 1) == 0)
                ch = CH_W'($urandom_range(0, CHANNELS - 1));
            if ($urandom_range(0, 4) != 0) begin
                bits = {wave_neg[ch], 31'($urandom_range(1, 32'h7F80_0000))};
                run_left[ch]--;
                if (run_left[ch] <= 0) begin
                    wave_neg[ch] = !wave_neg[ch];
                    run_left[ch] = $urandom_range(1, 12);
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: bits = $urandom;
                    1: bits = {1'($urandom_range(0, 1)), 31'd0};
                    2: bits = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
                    3: bits = {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
                    default: bits = {1'($urandom_range(0, 1)), 31'($urandom)};
                endcase
            end
            queue_word(ch, bits);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && o_s_tready)
                advance_channel(s_tdata[2:0], s_tdata[34:3]);
            if (!s_tvalid || o_s_tready) begin
                if (gap_left != 0 || word_q.size() == 0) begin
                    if (gap_left != 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= word_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 10);
                        gap_left   = $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_span = $urandom_range(8, 60);
            end else begin
                stall_span--;
            end
            stall_tick++;
            case (stall_mode)
                STALL_NONE:   m_tready <= 1'b1;
                STALL_COIN:   m_tready <= 1'($urandom_range(0, 1));
                STALL_EVERY4: m_tready <= (stall_tick % 4) != 0;
                default:      m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        period_stats_t got;
        period_stats_t want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = {o_m_tdata[2:0], o_m_tdata[34:3], o_m_tdata[66:35], o_m_tuser[0]};
            if (stats_q.size() == 0) begin
                flag_mismatch("unexpected word, channel", '0, 32'(got.ch));
            end else begin
                want = stats_q.pop_front();
                if (got.ch !== want.ch)
                    flag_mismatch("channel_out", 32'(want.ch), 32'(got.ch));
                if (got.lo !== want.lo)
                    flag_mismatch("min_period", want.lo, got.lo);
                if (got.hi !== want.hi)
                    flag_mismatch("max_period", want.hi, got.hi);
                if (got.closed !== want.closed)
                    flag_mismatch("period_closed", 32'(want.closed), 32'(got.closed));
            end
        end
    end

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            sign_r[c]     = SIGN_NONE;
            xing_r[c]     = '0;
            cnt_r[c]      = '0;
            shortest_r[c] = '0;
            longest_r[c]  = '0;
        end
        queue_directed();
        queue_random();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (word_q.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (stats_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && stats_q.size() == 0)
            $display("zero_crossing_period_tracker_core_test: done, clean");
        else
            $display("zero_crossing_period_tracker_core_test: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout");
        $display("zero_crossing_period_tracker_core_test: done, errors");
        $finish;
    end

endmodule
